>>> rtl/core/chji_pkg.sv
// chji_pkg: shared types, constants and fixed-point helpers of the cubic
// hermite joint interpolator core
// depends on nothing; used by every module under rtl/core
package chji_pkg;

    localparam int DEF_NUM_JOINTS   = 6;
    localparam int DEF_NUM_SEGMENTS = 256;
    localparam int DEF_DATA_WIDTH   = 32;

    localparam int COEF_W = 48;   // stored coefficient width, signed Q32.16
    localparam int ACC_W  = 54;   // evaluation accumulator, holds +-2^52
    localparam int NUM_W  = 64;   // divider numerator and quotient width
    localparam int DEN_W  = 32;   // divider denominator width

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ZERO_DUR = 2'd1;
    localparam logic [1:0] STATUS_SAT      = 2'd2;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    typedef struct packed {
        logic signed [COEF_W-1:0] c0;
        logic signed [COEF_W-1:0] c1;
        logic signed [COEF_W-1:0] c2;
        logic signed [COEF_W-1:0] c3;
    } coeff_entry_t;

    // quotient magnitude limited to 2^47
    function automatic logic [47:0] cap_mag47(input logic [NUM_W-1:0] quot);
        cap_mag47 = (quot > 64'h0000_8000_0000_0000) ? 48'h8000_0000_0000 : quot[47:0];
    endfunction

    function automatic logic signed [48:0] apply_sign49(input logic [47:0] mag,
                                                       input logic neg);
        logic signed [48:0] v;
        v = {1'b0, mag};
        apply_sign49 = neg ? -v : v;
    endfunction

    // clamp to magnitude 2^46
    function automatic logic signed [47:0] clamp46(input logic signed [49:0] v);
        if (v > 50'sh0_4000_0000_0000) begin
            clamp46 = 48'sh4000_0000_0000;
        end else if (v < -50'sh0_4000_0000_0000) begin
            clamp46 = -48'sh4000_0000_0000;
        end else begin
            clamp46 = v[47:0];
        end
    endfunction

    // saturate to 48 signed bits; the value never goes below -2^47
    function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
        sat48 = (v > 49'sh0_7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF : v[47:0];
    endfunction

    // numerator of a division by the duration: magnitude times 2^16
    function automatic logic [NUM_W-1:0] div_numer(input logic [47:0] mag);
        div_numer = {mag, 16'h0000};
    endfunction

    function automatic logic signed [ACC_W-1:0] sx48(input logic signed [47:0] v);
        sx48 = {{(ACC_W-48){v[47]}}, v};
    endfunction

endpackage

>>> rtl/core/chji_coeff_mem.sv
// chji_coeff_mem: coefficient store, one entry of four coefficients per
// segment and joint, one write and one registered read port
// depends on chji_pkg
module chji_coeff_mem #(
    parameter int DEPTH  = chji_pkg::DEF_NUM_SEGMENTS * chji_pkg::DEF_NUM_JOINTS,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  chji_pkg::coeff_entry_t wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output chji_pkg::coeff_entry_t rd_data
);

    chji_pkg::coeff_entry_t mem_array [DEPTH];
    chji_pkg::coeff_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/chji_div.sv
// chji_div: radix-2 restoring divider, 64-bit numerator by 32-bit divisor,
// one quotient bit per cycle
// depends on chji_pkg
module chji_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [chji_pkg::NUM_W-1:0]    numer,
    input  logic [chji_pkg::DEN_W-1:0]    denom,
    output logic                          done,
    output logic [chji_pkg::NUM_W-1:0]    quot
);

    localparam int CNT_W = $clog2(chji_pkg::NUM_W + 1);

    logic [chji_pkg::NUM_W-1:0] q_reg;
    logic [chji_pkg::DEN_W-1:0] d_reg;
    logic [chji_pkg::DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       done_reg;

    logic [chji_pkg::DEN_W:0]   trial;
    logic                       fits;

    always_comb begin
        trial = {rem_reg, q_reg[chji_pkg::NUM_W-1]};
        fits  = (trial >= {1'b0, d_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CNT_W'(chji_pkg::NUM_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= numer;
            d_reg   <= denom;
            rem_reg <= '0;
        end else if (cnt_reg != '0) begin
            rem_reg <= fits ? chji_pkg::DEN_W'(trial - {1'b0, d_reg})
                            : trial[chji_pkg::DEN_W-1:0];
            q_reg   <= {q_reg[chji_pkg::NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

>>> rtl/core/chji_mac.sv
// chji_mac: clamped horner step add + trunc(x*t/2^16) on one shared
// 32x32 multiplier, high and low halves of |x| in two passes
// depends on chji_pkg
module chji_mac (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [chji_pkg::ACC_W-1:0] add_in,
    input  logic signed [chji_pkg::ACC_W-1:0] x_in,
    input  logic [31:0]                       t_in,
    output logic                              done,
    output logic signed [chji_pkg::ACC_W-1:0] result
);

    localparam int ACC_W = chji_pkg::ACC_W;

    logic [1:0]              phase_reg;
    logic                    done_reg;
    logic                    neg_reg;
    logic [52:0]             m_reg;
    logic signed [ACC_W-1:0] add_reg;
    logic [31:0]             t_reg;
    logic [52:0]             hi_reg;
    logic [63:0]             lo_reg;
    logic signed [ACC_W-1:0] res_reg;

    logic [31:0]             mul_a;
    logic [63:0]             mul_p;
    logic [53:0]             p_sum;
    logic [52:0]             p_mag;
    logic signed [ACC_W-1:0] p_signed;
    logic signed [ACC_W:0]   total;
    logic signed [ACC_W-1:0] clamped;
    logic signed [ACC_W-1:0] x_abs;

    always_comb begin
        x_abs = x_in[ACC_W-1] ? -x_in : x_in;
        mul_a = (phase_reg == 2'd1) ? {11'b0, m_reg[52:32]} : m_reg[31:0];
        mul_p = mul_a * t_reg;
        p_sum = {1'b0, hi_reg[36:0], 16'h0000} + {6'b0, lo_reg[63:16]};
        if (hi_reg > 53'h0_0010_0000_0000) begin
            p_mag = 53'h10_0000_0000_0000;
        end else if (p_sum > 54'h10_0000_0000_0000) begin
            p_mag = 53'h10_0000_0000_0000;
        end else begin
            p_mag = p_sum[52:0];
        end
        p_signed = neg_reg ? -{1'b0, p_mag} : {1'b0, p_mag};
        total    = {add_reg[ACC_W-1], add_reg} + {p_signed[ACC_W-1], p_signed};
        if (total > 55'sh10_0000_0000_0000) begin
            clamped = 54'sh10_0000_0000_0000;
        end else if (total < -55'sh10_0000_0000_0000) begin
            clamped = -54'sh10_0000_0000_0000;
        end else begin
            clamped = total[ACC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 2'd0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= (phase_reg == 2'd3);
            unique case (phase_reg)
                2'd0: phase_reg <= start ? 2'd1 : 2'd0;
                2'd1: phase_reg <= 2'd2;
                2'd2: phase_reg <= 2'd3;
                2'd3: phase_reg <= 2'd0;
                default: phase_reg <= 2'd0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (start && phase_reg == 2'd0) begin
            neg_reg <= x_in[ACC_W-1];
            m_reg   <= x_abs[52:0];
            add_reg <= add_in;
            t_reg   <= t_in;
        end
        if (phase_reg == 2'd1) begin
            hi_reg <= mul_p[52:0];
        end
        if (phase_reg == 2'd2) begin
            lo_reg <= mul_p;
        end
        if (phase_reg == 2'd3) begin
            res_reg <= clamped;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

>>> rtl/core/cubic_hermite_joint_interpolator_core.sv
// cubic_hermite_joint_interpolator_core: top level, sequencer around the
// coefficient store, the shared divider and the shared multiply-add step
// depends on chji_pkg, chji_coeff_mem, chji_div, chji_mac
//
// usage
// - one input channel (s_*) carries load and evaluate transactions, one
//   result channel (m_*) returns exactly one result transaction for each
// - a load turns start/end position, velocity and duration of one segment
//   and joint into four coefficients kept in the coefficient store; its
//   result carries zero values and the status (zero duration rejected)
// - an evaluate reads the entry of one segment and joint and returns the
//   position, velocity and acceleration at the offset time, saturated
// - one transaction is worked at a time; s_ready is high while the
//   sequencer is idle
// - work per item: a load takes five passes of the serial divider; an
//   evaluate takes a store read, a division by three and six
//   multiply-add steps; loads with a zero duration and items with an
//   address out of range go straight from idle to the finish state
// - the finished result sits in an output register, so the next input
//   transaction is taken while the receiver stalls; only a second result
//   waits in the sequencer until the output register frees up
// - reset clears the sequencer and the valid flags; the coefficient store
//   is not cleared and an entry must be loaded before it is evaluated
module cubic_hermite_joint_interpolator_core #(
    parameter int NUM_JOINTS   = chji_pkg::DEF_NUM_JOINTS,
    parameter int NUM_SEGMENTS = chji_pkg::DEF_NUM_SEGMENTS,
    parameter int DATA_WIDTH   = chji_pkg::DEF_DATA_WIDTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic [7:0]         s_segment_index,
    input  logic [2:0]         s_joint_index,
    input  logic signed [31:0] s_start_position,
    input  logic signed [31:0] s_start_velocity,
    input  logic signed [31:0] s_end_position,
    input  logic signed [31:0] s_end_velocity,
    input  logic [31:0]        s_segment_duration,
    input  logic [31:0]        s_offset_time,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_position_out,
    output logic signed [31:0] m_velocity_out,
    output logic signed [31:0] m_acceleration_out,
    output logic [1:0]         m_status
);

    localparam int DEPTH    = NUM_SEGMENTS * NUM_JOINTS;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ACC_W    = chji_pkg::ACC_W;
    localparam int OUT_BITS = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam logic signed [ACC_W-1:0] SAT_HI = (54'sd1 <<< (OUT_BITS - 1)) - 54'sd1;
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - 54'sd1;
    // ceil(2^19 / 3), exact quotient for every 18-bit digit window
    localparam logic [35:0] RECIP3 = 36'd174763;

    // sequencer codes
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_L_Q    = 4'd1;   // 3*dp/T
    localparam logic [3:0] ST_L_U    = 4'd2;   // 2*u/T, gives c2
    localparam logic [3:0] ST_L_R    = 4'd3;   // -2*dp/T
    localparam logic [3:0] ST_L_W    = 4'd4;   // 3*w/T
    localparam logic [3:0] ST_L_Z    = 4'd5;   // z/T, gives c3, store write
    localparam logic [3:0] ST_E_RD   = 4'd6;   // store read data arrives
    localparam logic [3:0] ST_E_D3   = 4'd7;   // c3/3, 16 bits per cycle
    localparam logic [3:0] ST_E_MAC  = 4'd8;   // six horner steps
    localparam logic [3:0] ST_FINISH = 4'd9;   // hand result to output reg

    logic [3:0]         state_reg;
    logic               mode_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic signed [31:0] sp_reg;
    logic signed [31:0] sv_reg;
    logic signed [32:0] dp_reg;
    logic signed [33:0] evsv2_reg;     // end velocity + 2 * start velocity
    logic signed [32:0] evsv1_reg;     // end velocity + start velocity
    logic [31:0]        dur_reg;
    logic [31:0]        t_reg;
    logic signed [47:0] c2_reg;
    logic               w_neg_reg;

    // evaluation operands
    logic signed [47:0] e_c0_reg;
    logic signed [47:0] e_c1_reg;
    logic signed [47:0] e_c2_reg;
    logic signed [47:0] e_c3_reg;
    logic signed [47:0] e_c3d3_reg;
    logic signed [ACC_W-1:0] p_acc_reg;
    logic signed [ACC_W-1:0] v_acc_reg;
    logic [2:0]         step_reg;
    logic               mac_start_reg;

    // division of |c3| by three, one 16-bit digit per cycle
    logic [47:0]        d3_mag_reg;
    logic [31:0]        d3_quot_reg;
    logic [1:0]         d3_rem_reg;
    logic [1:0]         d3_cnt_reg;

    // result waiting for the output register
    logic signed [31:0] res_pos_reg;
    logic signed [31:0] res_vel_reg;
    logic signed [31:0] res_acc_reg;
    logic [1:0]         res_status_reg;

    // output register
    logic               m_valid_reg;
    logic signed [31:0] m_pos_reg;
    logic signed [31:0] m_vel_reg;
    logic signed [31:0] m_acc_reg;
    logic [1:0]         m_status_reg;

    // divider port
    logic                          div_start_reg;
    logic [chji_pkg::NUM_W-1:0]    div_numer_reg;
    logic [chji_pkg::DEN_W-1:0]    div_denom_reg;
    logic                          div_done;
    logic [chji_pkg::NUM_W-1:0]    div_quot;

    // mac port
    logic signed [ACC_W-1:0] mac_add;
    logic signed [ACC_W-1:0] mac_x;
    logic                    mac_done;
    logic signed [ACC_W-1:0] mac_result;

    // store port
    logic                   mem_wr_en;
    chji_pkg::coeff_entry_t mem_wr_data;
    logic                   mem_rd_en;
    logic [ADDR_W-1:0]      in_addr;
    chji_pkg::coeff_entry_t mem_rd_data;

    // input decode
    logic               accept;
    logic               in_ok;
    logic [31:0]        in_idx;
    logic signed [32:0] in_dp;
    logic signed [34:0] in_dp3;
    logic [34:0]        in_dp3_mag;

    // load datapath
    logic [47:0]        quot_cap;
    logic signed [48:0] q_val;
    logic signed [48:0] r_val;
    logic signed [47:0] u_val;
    logic signed [47:0] w_val;
    logic [47:0]        u_mag;
    logic [47:0]        w_mag;
    logic [33:0]        dp2_mag;
    logic signed [47:0] c3_val;

    // evaluation datapath
    logic [47:0]        rd_c3_mag;
    logic signed [48:0] c2_round;
    logic signed [47:0] c2_half;
    logic signed [47:0] c3d3_val;
    logic               sat_any;
    logic [17:0]        d3_val;
    logic [35:0]        d3_prod;
    logic [15:0]        d3_digit;
    logic [17:0]        d3_rem_full;
    logic [47:0]        d3_quot_next;

    function automatic logic signed [31:0] sat_out(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] c;
        c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
        sat_out = c[31:0];
    endfunction

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        in_ok  = ({24'b0, s_segment_index} < 32'(NUM_SEGMENTS))
              && ({29'b0, s_joint_index} < 32'(NUM_JOINTS));
        in_idx = {24'b0, s_segment_index} * 32'(NUM_JOINTS) + {29'b0, s_joint_index};
        in_addr = in_idx[ADDR_W-1:0];
        in_dp  = {s_end_position[31], s_end_position}
               - {s_start_position[31], s_start_position};
        in_dp3 = {{2{in_dp[32]}}, in_dp} + {in_dp[32], in_dp, 1'b0};
        in_dp3_mag = in_dp3[34] ? 35'(-in_dp3) : 35'(in_dp3);
    end

    always_comb begin
        quot_cap = chji_pkg::cap_mag47(div_quot);
        q_val    = chji_pkg::apply_sign49(quot_cap, dp_reg[32]);
        r_val    = chji_pkg::apply_sign49(quot_cap, !dp_reg[32]);
        u_val    = chji_pkg::clamp46({q_val[48], q_val} - {{16{evsv2_reg[33]}}, evsv2_reg});
        w_val    = chji_pkg::clamp46({r_val[48], r_val} + {{17{evsv1_reg[32]}}, evsv1_reg});
        u_mag    = u_val[47] ? 48'(-u_val) : 48'(u_val);
        w_mag    = w_val[47] ? 48'(-w_val) : 48'(w_val);
        dp2_mag  = dp_reg[32] ? 34'(-{dp_reg, 1'b0}) : 34'({dp_reg, 1'b0});
        c3_val   = chji_pkg::sat48(chji_pkg::apply_sign49(quot_cap, w_neg_reg));
        // the sign of u for the c2 step is kept in c2_reg
    end

    always_comb begin
        rd_c3_mag = mem_rd_data.c3[47] ? 48'(-mem_rd_data.c3) : 48'(mem_rd_data.c3);
        // next digit of |c3|/3: remainder so far and the next 16 bits
        d3_val       = {d3_rem_reg, d3_mag_reg[47:32]};
        d3_prod      = 36'(d3_val) * RECIP3;
        d3_digit     = d3_prod[34:19];
        d3_rem_full  = d3_val - ({1'b0, d3_digit, 1'b0} + {2'b0, d3_digit});
        d3_quot_next = {d3_quot_reg, d3_digit};
        c3d3_val  = e_c3_reg[47] ? -$signed(d3_quot_next) : $signed(d3_quot_next);
        // c2/2 truncated toward zero
        c2_round  = {e_c2_reg[47], e_c2_reg} + {48'b0, e_c2_reg[47]};
        c2_half   = c2_round[48:1];
    end

    // horner step operands
    always_comb begin
        unique case (step_reg)
            3'd0: begin mac_add = chji_pkg::sx48(c2_half);  mac_x = chji_pkg::sx48(e_c3d3_reg); end
            3'd1: begin mac_add = chji_pkg::sx48(e_c1_reg); mac_x = p_acc_reg; end
            3'd2: begin mac_add = chji_pkg::sx48(e_c0_reg); mac_x = p_acc_reg; end
            3'd3: begin mac_add = chji_pkg::sx48(e_c2_reg); mac_x = chji_pkg::sx48(e_c3_reg); end
            3'd4: begin mac_add = chji_pkg::sx48(e_c1_reg); mac_x = v_acc_reg; end
            default: begin
                mac_add = chji_pkg::sx48(e_c2_reg);
                mac_x   = {{(ACC_W-49){e_c3_reg[47]}}, e_c3_reg, 1'b0};
            end
        endcase
    end

    always_comb begin
        sat_any = (p_acc_reg > SAT_HI) || (p_acc_reg < SAT_LO)
               || (v_acc_reg > SAT_HI) || (v_acc_reg < SAT_LO)
               || (mac_result > SAT_HI) || (mac_result < SAT_LO);
        mem_rd_en = accept && (s_mode == chji_pkg::MODE_EVAL) && in_ok;
        mem_wr_en = (state_reg == ST_L_Z) && div_done;
        mem_wr_data.c0 = {{16{sp_reg[31]}}, sp_reg};
        mem_wr_data.c1 = {{16{sv_reg[31]}}, sv_reg};
        mem_wr_data.c2 = c2_reg;
        mem_wr_data.c3 = c3_val;
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            div_start_reg <= 1'b0;
            mac_start_reg <= 1'b0;
            step_reg      <= 3'd0;
        end else begin
            div_start_reg <= 1'b0;
            mac_start_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (s_mode == chji_pkg::MODE_LOAD) begin
                            if (s_segment_duration == '0 || !in_ok) begin
                                state_reg <= ST_FINISH;
                            end else begin
                                state_reg     <= ST_L_Q;
                                div_start_reg <= 1'b1;
                            end
                        end else begin
                            state_reg <= in_ok ? ST_E_RD : ST_FINISH;
                        end
                    end
                end
                ST_L_Q: if (div_done) begin
                    state_reg <= ST_L_U; div_start_reg <= 1'b1;
                end
                ST_L_U: if (div_done) begin
                    state_reg <= ST_L_R; div_start_reg <= 1'b1;
                end
                ST_L_R: if (div_done) begin
                    state_reg <= ST_L_W; div_start_reg <= 1'b1;
                end
                ST_L_W: if (div_done) begin
                    state_reg <= ST_L_Z; div_start_reg <= 1'b1;
                end
                ST_L_Z: if (div_done) begin
                    state_reg <= ST_FINISH;
                end
                ST_E_RD: begin
                    state_reg <= ST_E_D3;
                end
                ST_E_D3: if (d3_cnt_reg == 2'd2) begin
                    state_reg <= ST_E_MAC; step_reg <= 3'd0; mac_start_reg <= 1'b1;
                end
                ST_E_MAC: if (mac_done) begin
                    if (step_reg == 3'd5) begin
                        state_reg <= ST_FINISH;
                    end else begin
                        step_reg <= step_reg + 3'd1; mac_start_reg <= 1'b1;
                    end
                end
                ST_FINISH: if (!m_valid_reg || m_ready) begin
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg  <= s_mode;
            addr_reg  <= in_addr;
            sp_reg    <= s_start_position;
            sv_reg    <= s_start_velocity;
            dp_reg    <= in_dp;
            evsv2_reg <= {{2{s_end_velocity[31]}}, s_end_velocity}
                       + {s_start_velocity[31], s_start_velocity, 1'b0};
            evsv1_reg <= {s_end_velocity[31], s_end_velocity}
                       + {s_start_velocity[31], s_start_velocity};
            dur_reg   <= s_segment_duration;
            t_reg     <= s_offset_time;
            div_numer_reg  <= chji_pkg::div_numer({13'b0, in_dp3_mag});
            div_denom_reg  <= s_segment_duration;
            res_pos_reg    <= '0;
            res_vel_reg    <= '0;
            res_acc_reg    <= '0;
            res_status_reg <= (s_mode == chji_pkg::MODE_LOAD && s_segment_duration == '0)
                            ? chji_pkg::STATUS_ZERO_DUR : chji_pkg::STATUS_OK;
        end
        unique case (state_reg)
            ST_L_Q: if (div_done) begin
                // u kept through the divider numerator, its sign by c2 step
                c2_reg        <= u_val;
                div_numer_reg <= chji_pkg::div_numer({u_mag[46:0], 1'b0});
            end
            ST_L_U: if (div_done) begin
                c2_reg        <= chji_pkg::sat48(chji_pkg::apply_sign49(quot_cap, c2_reg[47]));
                div_numer_reg <= chji_pkg::div_numer({14'b0, dp2_mag});
            end
            ST_L_R: if (div_done) begin
                w_neg_reg     <= w_val[47];
                div_numer_reg <= chji_pkg::div_numer(w_mag + {w_mag[46:0], 1'b0});
            end
            ST_L_W: if (div_done) begin
                div_numer_reg <= chji_pkg::div_numer(quot_cap);
            end
            ST_E_RD: begin
                e_c0_reg   <= mem_rd_data.c0;
                e_c1_reg   <= mem_rd_data.c1;
                e_c2_reg   <= mem_rd_data.c2;
                e_c3_reg   <= mem_rd_data.c3;
                d3_mag_reg <= rd_c3_mag;
                d3_rem_reg <= 2'd0;
                d3_cnt_reg <= 2'd0;
            end
            ST_E_D3: begin
                d3_mag_reg  <= {d3_mag_reg[31:0], 16'h0000};
                d3_rem_reg  <= d3_rem_full[1:0];
                d3_quot_reg <= d3_quot_next[31:0];
                d3_cnt_reg  <= d3_cnt_reg + 2'd1;
                if (d3_cnt_reg == 2'd2) begin
                    e_c3d3_reg <= c3d3_val;
                end
            end
            ST_E_MAC: if (mac_done) begin
                if (step_reg <= 3'd2) begin
                    p_acc_reg <= mac_result;
                end else if (step_reg <= 3'd4) begin
                    v_acc_reg <= mac_result;
                end else begin
                    res_pos_reg    <= sat_out(p_acc_reg);
                    res_vel_reg    <= sat_out(v_acc_reg);
                    res_acc_reg    <= sat_out(mac_result);
                    res_status_reg <= sat_any ? chji_pkg::STATUS_SAT : chji_pkg::STATUS_OK;
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_FINISH && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FINISH && (!m_valid_reg || m_ready)) begin
            m_pos_reg    <= res_pos_reg;
            m_vel_reg    <= res_vel_reg;
            m_acc_reg    <= res_acc_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_position_out     = m_pos_reg;
    assign m_velocity_out     = m_vel_reg;
    assign m_acceleration_out = m_acc_reg;
    assign m_status           = m_status_reg;

    chji_coeff_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (addr_reg),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (in_addr),
        .rd_data (mem_rd_data)
    );

    chji_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .numer   (div_numer_reg),
        .denom   (div_denom_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    chji_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mac_start_reg),
        .add_in  (mac_add),
        .x_in    (mac_x),
        .t_in    (t_reg),
        .done    (mac_done),
        .result  (mac_result)
    );

    // a zero-duration load never reaches the store
    a_wr_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> (dur_reg != '0))
        else $error("coefficient write for a zero duration");

    // the divider only finishes while a transaction is in work
    a_div_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !div_done)
        else $error("divider done while idle");

    // horner steps only complete in the evaluation phase
    a_mac_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_done |-> (state_reg == ST_E_MAC))
        else $error("multiply-add done outside evaluation");

    // a load never reports a saturated result
    a_load_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && mode_reg == chji_pkg::MODE_LOAD)
            |-> (res_status_reg != chji_pkg::STATUS_SAT))
        else $error("load reported saturation");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench of cubic_hermite_joint_interpolator_core
// depends on chji_pkg and the core; predicts every result with its own fixed-point model
module tb;

    localparam int NJ = chji_pkg::DEF_NUM_JOINTS;
    localparam int NS = chji_pkg::DEF_NUM_SEGMENTS;
    localparam int DEPTH = NJ * NS;
    localparam logic [63:0] CAP47 = 64'h0000_8000_0000_0000;
    localparam longint CAP46 = 64'sh0000_4000_0000_0000;
    localparam logic [63:0] LIM52 = 64'h0010_0000_0000_0000;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam int TAIL_CYCLES = 400;

    // one result transaction
    typedef struct {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] acc;
        logic [1:0]         st;
    } motion_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_mode;
    logic [7:0]         s_segment_index;
    logic [2:0]         s_joint_index;
    logic signed [31:0] s_start_position;
    logic signed [31:0] s_start_velocity;
    logic signed [31:0] s_end_position;
    logic signed [31:0] s_end_velocity;
    logic [31:0]        s_segment_duration;
    logic [31:0]        s_offset_time;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_position_out;
    logic signed [31:0] m_velocity_out;
    logic signed [31:0] m_acceleration_out;
    logic [1:0]         m_status;

    // predictor copy of the coefficient store
    longint      c0_tab [DEPTH];
    longint      c1_tab [DEPTH];
    longint      c2_tab [DEPTH];
    longint      c3_tab [DEPTH];
    logic [31:0] dur_tab [DEPTH];
    int          loaded_q [$];
    bit          loaded_tab [DEPTH];

    motion_t     pending_q [$];
    int          fail_count = 0;
    longint      cycle_count = 0;
    bit          no_gaps = 1'b0;
    int          hold_cycles = 0;

    always #5 aclk = ~aclk;

    cubic_hermite_joint_interpolator_core u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_mode             (s_mode),
        .s_segment_index    (s_segment_index),
        .s_joint_index      (s_joint_index),
        .s_start_position   (s_start_position),
        .s_start_velocity   (s_start_velocity),
        .s_end_position     (s_end_position),
        .s_end_velocity     (s_end_velocity),
        .s_segment_duration (s_segment_duration),
        .s_offset_time      (s_offset_time),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_position_out     (m_position_out),
        .m_velocity_out     (m_velocity_out),
        .m_acceleration_out (m_acceleration_out),
        .m_status           (m_status)
    );

    // ---------------------------------------------------------------
    // fixed-point predictor
    // ---------------------------------------------------------------

    function automatic logic [63:0] magnitude(input longint x);
        magnitude = (x < 0) ? 64'(-x) : 64'(x);
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        clip = (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // sign(x) * min(trunc(|x|*k*2^16/tt), 2^47), done on magnitudes
    function automatic longint scaled_quot(input longint x, input logic [63:0] k,
                                           input logic [31:0] tt);
        logic [63:0] q;
        q = ((magnitude(x) * k) << 16) / {32'h0, tt};
        if (q > CAP47) q = CAP47;
        scaled_quot = (x < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint sat_coef(input longint v);
        sat_coef = clip(v, -longint'(CAP47), longint'(CAP47) - 1);
    endfunction

    // one horner step: add + trunc(x*t/2^16), clamped to magnitude 2^52
    function automatic longint horner_step(input longint add, input longint x,
                                           input logic [31:0] t);
        logic [63:0] m;
        logic [63:0] hi;
        logic [63:0] p;
        longint      s;
        m  = magnitude(x);
        hi = (m >> 32) * {32'h0, t};
        if (hi > (LIM52 >> 16)) begin
            p = LIM52;
        end else begin
            p = (hi << 16) + (((m & 64'hFFFF_FFFF) * {32'h0, t}) >> 16);
            if (p > LIM52) p = LIM52;
        end
        s = (x < 0) ? -longint'(p) : longint'(p);
        horner_step = clip(add + s, -longint'(LIM52), longint'(LIM52));
    endfunction

    function automatic logic signed [31:0] sat_out32(input longint v, inout bit sat);
        if (v > 64'sd2147483647) begin
            v = 64'sd2147483647;
            sat = 1'b1;
        end
        if (v < -64'sd2147483648) begin
            v = -64'sd2147483648;
            sat = 1'b1;
        end
        sat_out32 = v[31:0];
    endfunction

    // works out the result of one accepted transaction and updates the store copy
    function automatic motion_t predict_motion(input logic mode, input logic [7:0] seg,
            input logic [2:0] jnt, input logic signed [31:0] sp, input logic signed [31:0] sv,
            input logic signed [31:0] ep, input logic signed [31:0] ev,
            input logic [31:0] dur, input logic [31:0] t);
        motion_t r;
        bit      in_range;
        int      idx;
        longint  dp, u, w, z, p, v, a;
        bit      sat;
        r = '{pos: 0, vel: 0, acc: 0, st: chji_pkg::STATUS_OK};
        in_range = (int'(seg) < NS) && (int'(jnt) < NJ);
        idx = int'(seg) * NJ + int'(jnt);
        sat = 1'b0;
        if (mode == chji_pkg::MODE_LOAD) begin
            if (dur == 0) begin
                r.st = chji_pkg::STATUS_ZERO_DUR;
            end else if (in_range) begin
                dp = longint'(ep) - longint'(sp);
                u = clip(scaled_quot(3 * dp, 64'd1, dur) - (longint'(ev) + 2 * longint'(sv)),
                         -CAP46, CAP46);
                w = clip(scaled_quot(-2 * dp, 64'd1, dur) + (longint'(ev) + longint'(sv)),
                         -CAP46, CAP46);
                z = scaled_quot(w, 64'd3, dur);
                c0_tab[idx]  = sp;
                c1_tab[idx]  = sv;
                c2_tab[idx]  = sat_coef(scaled_quot(u, 64'd2, dur));
                c3_tab[idx]  = sat_coef(scaled_quot(z, 64'd1, dur));
                dur_tab[idx] = dur;
                if (!loaded_tab[idx]) begin
                    loaded_tab[idx] = 1'b1;
                    loaded_q = {loaded_q, idx};
                end
            end
        end else if (in_range) begin
            p = horner_step(c2_tab[idx] / 2, c3_tab[idx] / 3, t);
            p = horner_step(c1_tab[idx], p, t);
            p = horner_step(c0_tab[idx], p, t);
            v = horner_step(c2_tab[idx], c3_tab[idx], t);
            v = horner_step(c1_tab[idx], v, t);
            a = horner_step(c2_tab[idx], 2 * c3_tab[idx], t);
            r.pos = sat_out32(p, sat);
            r.vel = sat_out32(v, sat);
            r.acc = sat_out32(a, sat);
            r.st  = sat ? chji_pkg::STATUS_SAT : chji_pkg::STATUS_OK;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (no_gaps || roll < 60) return 0;
        if (roll < 94) return $urandom_range(4, 1);
        return $urandom_range(120, 20);
    endfunction

    // offers one transaction, holds it until accepted, then may idle a while
    task automatic send_item(input logic mode, input logic [7:0] seg, input logic [2:0] jnt,
            input logic [31:0] sp, input logic [31:0] sv, input logic [31:0] ep,
            input logic [31:0] ev, input logic [31:0] dur, input logic [31:0] t);
        int gap;
        s_valid            <= 1'b1;
        s_mode             <= mode;
        s_segment_index    <= seg;
        s_joint_index      <= jnt;
        s_start_position   <= sp;
        s_start_velocity   <= sv;
        s_end_position     <= ep;
        s_end_velocity     <= ev;
        s_segment_duration <= dur;
        s_offset_time      <= t;
        do @(posedge aclk); while (!s_ready);
        pending_q = {pending_q, predict_motion(mode, seg, jnt, sp, sv, ep, ev, dur, t)};
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_load(input logic [7:0] seg, input logic [2:0] jnt,
            input logic [31:0] sp, input logic [31:0] sv, input logic [31:0] ep,
            input logic [31:0] ev, input logic [31:0] dur);
        send_item(chji_pkg::MODE_LOAD, seg, jnt, sp, sv, ep, ev, dur, $urandom);
    endtask

    task automatic send_eval(input logic [7:0] seg, input logic [2:0] jnt,
                             input logic [31:0] t);
        send_item(chji_pkg::MODE_EVAL, seg, jnt, $urandom, $urandom, $urandom, $urandom,
                  $urandom, t);
    endtask

    // random load with either realistic or full-range content
    task automatic random_load(input logic [7:0] seg, input logic [2:0] jnt);
        logic [31:0] dur;
        if ($urandom_range(1)) begin
            dur = $urandom_range(32'h0010_0000, 32'h0000_4000);
            send_load(seg, jnt, $urandom_range(32'h0200_0000) - 32'h0100_0000,
                      $urandom_range(32'h0080_0000) - 32'h0040_0000,
                      $urandom_range(32'h0200_0000) - 32'h0100_0000,
                      $urandom_range(32'h0080_0000) - 32'h0040_0000, dur);
        end else begin
            dur = ($urandom_range(19) == 0) ? 32'h0 : $urandom;
            send_load(seg, jnt, $urandom, $urandom, $urandom, $urandom, dur);
        end
    endtask

    // evaluate of an entry that holds coefficients, mostly inside its segment
    task automatic random_eval();
        int          idx;
        logic [31:0] t;
        idx = loaded_q[$urandom_range(loaded_q.size() - 1)];
        if ($urandom_range(3) != 0) t = $urandom_range(dur_tab[idx]);
        else t = $urandom;
        send_eval(8'(idx / NJ), 3'(idx % NJ), t);
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // extremes of the load fields, zero duration, joints out of range
    task automatic test_directed_loads();
        send_load(8'd0, 3'd0, 32'h0001_0000, 32'h0000_8000, 32'h000A_0000,
                  32'hFFFF_0000, 32'h0002_0000);
        send_load(8'd255, 3'd5, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h0000_0001);
        send_load(8'd17, 3'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h8000_0000, 32'hFFFF_FFFF);
        send_load(8'd128, 3'd2, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                  32'h0000_0000, 32'h0001_0000);
        send_load(8'd1, 3'd1, 32'h0000_1000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h0000_0000, 32'h0000_0010);
        // zero duration is flagged, in and out of range
        send_load(8'd2, 3'd0, 32'h1234_5678, 32'h0, 32'h0, 32'h0, 32'h0);
        send_load(8'd3, 3'd7, 32'h1234_5678, 32'h0, 32'h0, 32'h0, 32'h0);
        // joint out of range: nothing stored
        send_load(8'd4, 3'd6, 32'h0001_0000, 32'h0, 32'h0002_0000, 32'h0, 32'h0001_0000);
    endtask

    // offsets at zero, inside, at the end and far past a segment
    task automatic test_directed_evals();
        send_eval(8'd0, 3'd0, 32'h0000_0000);
        send_eval(8'd0, 3'd0, 32'h0001_0000);
        send_eval(8'd0, 3'd0, 32'h0002_0000);
        send_eval(8'd0, 3'd0, 32'hFFFF_FFFF);
        send_eval(8'd255, 3'd5, 32'h0000_0001);
        send_eval(8'd255, 3'd5, 32'hFFFF_FFFF);
        send_eval(8'd17, 3'd3, 32'h8000_0000);
        send_eval(8'd128, 3'd2, 32'hFFFF_FFFF);
        send_eval(8'd1, 3'd1, 32'h0000_0008);
        send_eval(8'd4, 3'd6, 32'h0000_8000);
        send_eval(8'd9, 3'd7, 32'hFFFF_FFFF);
    endtask

    // receiver holds off for a long stretch while items keep coming
    task automatic test_backpressure();
        int k;
        hold_cycles = 3000;
        for (k = 0; k < 6; k++) begin
            if (k % 2 == 0) random_load(8'($urandom_range(255)), 3'($urandom_range(5)));
            else random_eval();
        end
    endtask

    // random mix of loads, evaluates and out-of-range items, first stretch without idling
    task automatic test_random(input int count);
        int k;
        int roll;
        for (k = 0; k < count; k++) begin
            no_gaps = (k < 60);
            roll = $urandom_range(99);
            if (roll < 5) begin
                send_item(1'($urandom_range(1)), 8'($urandom), 3'($urandom_range(7, 6)),
                          $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else if (roll < 45 || loaded_q.size() == 0) begin
                random_load(8'($urandom_range(255)), 3'($urandom_range(5)));
            end else begin
                random_eval();
            end
        end
        no_gaps = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // result side: random stalls and the checker
    // ---------------------------------------------------------------

    initial begin
        int idle_left;
        idle_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else if (idle_left > 0) begin
                m_ready <= 1'b0;
                idle_left--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(4) == 0) idle_left = pick_gap();
            end
        end
    end

    // compares each result transaction with the oldest prediction
    always @(posedge aclk) begin
        motion_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_q.size() == 0) begin
                $error("result with no prediction waiting");
                fail_count++;
            end else begin
                want = pending_q.pop_front();
                if (m_position_out !== want.pos) begin
                    $error("position_out expected %0d actual %0d", want.pos, m_position_out);
                    fail_count++;
                end
                if (m_velocity_out !== want.vel) begin
                    $error("velocity_out expected %0d actual %0d", want.vel, m_velocity_out);
                    fail_count++;
                end
                if (m_acceleration_out !== want.acc) begin
                    $error("acceleration_out expected %0d actual %0d",
                           want.acc, m_acceleration_out);
                    fail_count++;
                end
                if (m_status !== want.st) begin
                    $error("status expected %0d actual %0d", want.st, m_status);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // sequence of the run
    // ---------------------------------------------------------------

    initial begin
        aresetn            <= 1'b0;
        s_valid            <= 1'b0;
        s_mode             <= chji_pkg::MODE_LOAD;
        s_segment_index    <= '0;
        s_joint_index      <= '0;
        s_start_position   <= '0;
        s_start_velocity   <= '0;
        s_end_position     <= '0;
        s_end_velocity     <= '0;
        s_segment_duration <= '0;
        s_offset_time      <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_loads();
        test_directed_evals();
        test_backpressure();
        test_random(400);
        s_valid <= 1'b0;

        // drain, then let the core settle
        wait (pending_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> cubic_hermite_joint_interpolator_core.f
rtl/core/chji_pkg.sv
rtl/core/chji_coeff_mem.sv
rtl/core/chji_div.sv
rtl/core/chji_mac.sv
rtl/core/cubic_hermite_joint_interpolator_core.sv
tb/tb.sv
